// ----- rtl/core/uf_pkg.sv -----
`timescale 1ns / 1ps

package uf_pkg;

   // Field widths of the request, response and configuration ports.
   localparam int FUNC_W = 2;
   localparam int NODE_W = 10;
   localparam int NCNT_W = 11;

   // Default table depth and the node count that reset selects.
   localparam int MAX_NODES_DEFAULT = 1024;
   localparam int NODE_COUNT_RESET  = 1024;

   // Request operation codes.
   localparam logic [FUNC_W-1:0] FUNC_MERGE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FIND_CHK1,
      S_FIND_CHK2,
      S_SIZE_A,
      S_SIZE_B,
      S_DONE
   } state_type;

endpackage

// ----- rtl/core/uf_req_if.sv -----
`timescale 1ns / 1ps

interface uf_req_if;
   import uf_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [NODE_W-1:0] node_a;
   logic [NODE_W-1:0] node_b;

   modport source (output valid, output func, output node_a, output node_b, input ready);
   modport sink   (input valid, input func, input node_a, input node_b, output ready);
endinterface

// ----- rtl/core/uf_rsp_if.sv -----
`timescale 1ns / 1ps

interface uf_rsp_if;
   import uf_pkg::*;

   logic              valid;
   logic              ready;
   logic              same_set;
   logic [NODE_W-1:0] root_index;
   logic              out_of_range;

   modport source (output valid, output same_set, output root_index, output out_of_range,
                   input ready);
   modport sink   (input valid, input same_set, input root_index, input out_of_range,
                   output ready);
endinterface

// ----- rtl/core/union_find_engine_unit.sv -----
`timescale 1ns / 1ps

// Disjoint-set engine with union by size and path halving. Each request transaction is a
// merge, a connected query or a find, and yields exactly one response transaction. The
// parent table sits in a RAM with one write port and one registered read port, so each
// halving step of a root walk passes through S_FIND_CHK1 and then S_FIND_CHK2 (read the
// parent, then read on from the grandparent while the halving write goes in). A request
// with an index out of range, or with the unused selector, goes straight to S_DONE.
// A new request is taken only when the previous one has finished its work; a finished
// response waits in its own output register, so the next request can start meanwhile.
// If the previous response is still waiting there, the finished request holds the block
// until the output register frees up.
// After reset and after every write of node_count the tables are rebuilt by a clearing
// pass over the node_count entries in use, during which no request is taken.
module union_find_engine_unit #(
   parameter int MAX_NODES = uf_pkg::MAX_NODES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   uf_req_if.sink                    req_ch,
   uf_rsp_if.source                  rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [uf_pkg::NCNT_W-1:0] csr_wr_data
);
   import uf_pkg::*;

   localparam int ADDR_W = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
   localparam int SIZE_W = $clog2(MAX_NODES + 1);
   localparam int CMP_W  = (ADDR_W > NCNT_W) ? ADDR_W : NCNT_W;
   localparam int NCNT_RST = (MAX_NODES < NODE_COUNT_RESET) ? MAX_NODES : NODE_COUNT_RESET;

   // Tables.
   logic [ADDR_W-1:0] parent_mem [MAX_NODES];
   logic [SIZE_W-1:0] size_mem   [MAX_NODES];

   // Control registers.
   state_type         state_ff, state_in;
   logic [NCNT_W-1:0] node_count_ff, node_count_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              phase_b_ff, phase_b_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Working registers of the current request.
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [ADDR_W-1:0] node_b_ff, node_b_in;
   logic [ADDR_W-1:0] cur_ff, cur_in;
   logic [ADDR_W-1:0] root_a_ff, root_a_in;
   logic [ADDR_W-1:0] root_b_ff, root_b_in;
   logic [SIZE_W-1:0] size_a_ff, size_a_in;
   logic              res_same_ff, res_same_in;
   logic [ADDR_W-1:0] res_root_ff, res_root_in;
   logic              res_oor_ff, res_oor_in;

   // Response output register.
   logic              rsp_same_ff, rsp_same_in;
   logic [ADDR_W-1:0] rsp_root_ff, rsp_root_in;
   logic              rsp_oor_ff, rsp_oor_in;

   // Memory ports.
   logic [ADDR_W-1:0] par_raddr, par_waddr, par_wdata, par_rdata_ff;
   logic              par_we;
   logic [ADDR_W-1:0] size_raddr, size_waddr;
   logic [SIZE_W-1:0] size_wdata, size_rdata_ff;
   logic              size_we;

   logic [NCNT_W-1:0] ncnt_clamp;
   logic              a_oor, b_oor;

   // Parent table: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (par_we) begin
         parent_mem[par_waddr] <= par_wdata;
      end
      par_rdata_ff <= parent_mem[par_raddr];
   end

   // Size table: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem[size_waddr] <= size_wdata;
      end
      size_rdata_ff <= size_mem[size_raddr];
   end

   // A written node count of zero counts as one, and one above the table depth saturates.
   always_comb begin
      ncnt_clamp = csr_wr_data;
      if (csr_wr_data == '0) begin
         ncnt_clamp = NCNT_W'(1);
      end else if (32'(csr_wr_data) > MAX_NODES) begin
         ncnt_clamp = NCNT_W'(MAX_NODES);
      end
   end

   // Range checks on the incoming indexes.
   assign a_oor = {1'b0, req_ch.node_a} >= node_count_ff;
   assign b_oor = {1'b0, req_ch.node_b} >= node_count_ff;

   // State register and request registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         node_count_ff <= NCNT_W'(NCNT_RST);
         clr_addr_ff   <= '0;
         phase_b_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         clr_addr_ff   <= clr_addr_in;
         phase_b_ff    <= phase_b_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      func_ff     <= func_in;
      node_b_ff   <= node_b_in;
      cur_ff      <= cur_in;
      root_a_ff   <= root_a_in;
      root_b_ff   <= root_b_in;
      size_a_ff   <= size_a_in;
      res_same_ff <= res_same_in;
      res_root_ff <= res_root_in;
      res_oor_ff  <= res_oor_in;
      rsp_same_ff <= rsp_same_in;
      rsp_root_ff <= rsp_root_in;
      rsp_oor_ff  <= rsp_oor_in;
   end

   // Sequencer: next state, memory ports and result assembly.
   always_comb begin
      state_in      = state_ff;
      node_count_in = node_count_ff;
      clr_addr_in   = clr_addr_ff;
      phase_b_in    = phase_b_ff;
      func_in       = func_ff;
      node_b_in     = node_b_ff;
      cur_in        = cur_ff;
      root_a_in     = root_a_ff;
      root_b_in     = root_b_ff;
      size_a_in     = size_a_ff;
      res_same_in   = res_same_ff;
      res_root_in   = res_root_ff;
      res_oor_in    = res_oor_ff;
      rsp_same_in   = rsp_same_ff;
      rsp_root_in   = rsp_root_ff;
      rsp_oor_in    = rsp_oor_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;

      par_raddr  = cur_ff;
      par_we     = 1'b0;
      par_waddr  = cur_ff;
      par_wdata  = par_rdata_ff;
      size_raddr = root_a_ff;
      size_we    = 1'b0;
      size_waddr = clr_addr_ff;
      size_wdata = SIZE_W'(1);

      case (state_ff)
         // Rebuild singletons over the nodes in use, one entry a cycle.
         S_CLEAR: begin
            par_we     = 1'b1;
            par_waddr  = clr_addr_ff;
            par_wdata  = clr_addr_ff;
            size_we    = 1'b1;
            size_waddr = clr_addr_ff;
            size_wdata = SIZE_W'(1);
            if (CMP_W'(clr_addr_ff) == CMP_W'(node_count_ff - NCNT_W'(1))) begin
               state_in = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + ADDR_W'(1);
            end
         end

         // Take a request and start the walk from node_a.
         S_IDLE: begin
            par_raddr = ADDR_W'(req_ch.node_a);
            if (req_ch.valid) begin
               func_in     = req_ch.func;
               node_b_in   = ADDR_W'(req_ch.node_b);
               cur_in      = ADDR_W'(req_ch.node_a);
               phase_b_in  = 1'b0;
               res_same_in = 1'b0;
               res_root_in = '0;
               res_oor_in  = 1'b0;
               if (req_ch.func != FUNC_MERGE && req_ch.func != FUNC_QUERY &&
                   req_ch.func != FUNC_FIND) begin
                  state_in = S_DONE;
               end else if (a_oor || (req_ch.func != FUNC_FIND && b_oor)) begin
                  res_oor_in = 1'b1;
                  state_in   = S_DONE;
               end else begin
                  state_in = S_FIND_CHK1;
               end
            end
         end

         // The parent of the current node is in; a self-parent marks the root.
         S_FIND_CHK1: begin
            if (par_rdata_ff == cur_ff) begin
               if (!phase_b_ff) begin
                  root_a_in = cur_ff;
                  if (func_ff == FUNC_FIND) begin
                     res_root_in = cur_ff;
                     state_in    = S_DONE;
                  end else begin
                     phase_b_in = 1'b1;
                     cur_in     = node_b_ff;
                     par_raddr  = node_b_ff;
                  end
               end else begin
                  root_b_in = cur_ff;
                  if (root_a_ff == cur_ff) begin
                     res_same_in = 1'b1;
                     res_root_in = root_a_ff;
                     state_in    = S_DONE;
                  end else if (func_ff == FUNC_QUERY) begin
                     res_root_in = root_a_ff;
                     state_in    = S_DONE;
                  end else begin
                     size_raddr = root_a_ff;
                     state_in   = S_SIZE_A;
                  end
               end
            end else begin
               par_raddr = par_rdata_ff;
               state_in  = S_FIND_CHK2;
            end
         end

         // Grandparent is in: re-point the node to it and step there.
         S_FIND_CHK2: begin
            par_we    = 1'b1;
            par_waddr = cur_ff;
            par_wdata = par_rdata_ff;
            par_raddr = par_rdata_ff;
            cur_in    = par_rdata_ff;
            state_in  = S_FIND_CHK1;
         end

         // Size of the first root is in; fetch the second.
         S_SIZE_A: begin
            size_a_in  = size_rdata_ff;
            size_raddr = root_b_ff;
            state_in   = S_SIZE_B;
         end

         // Link the smaller set under the larger; ties go under the second root.
         S_SIZE_B: begin
            par_we     = 1'b1;
            size_we    = 1'b1;
            size_wdata = size_a_ff + size_rdata_ff;
            if (size_a_ff > size_rdata_ff) begin
               par_waddr   = root_b_ff;
               par_wdata   = root_a_ff;
               size_waddr  = root_a_ff;
               res_root_in = root_a_ff;
            end else begin
               par_waddr   = root_a_ff;
               par_wdata   = root_b_ff;
               size_waddr  = root_b_ff;
               res_root_in = root_b_ff;
            end
            state_in = S_DONE;
         end

         // Hand the result to the output register once it is free.
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_same_in  = res_same_ff;
               rsp_root_in  = res_root_ff;
               rsp_oor_in   = res_oor_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A node count write restarts the clearing pass.
      if (csr_wr_en) begin
         node_count_in = ncnt_clamp;
         clr_addr_in   = '0;
         state_in      = S_CLEAR;
      end
   end

   // Channel outputs.
   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.same_set     = rsp_same_ff;
   assign rsp_ch.root_index   = NODE_W'(rsp_root_ff);
   assign rsp_ch.out_of_range = rsp_oor_ff;

   // A new response only ever comes out of the completion state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside the completion state");

   // A rejected request carries no set information.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_oor_ff) |-> (!rsp_same_ff && rsp_root_ff == '0))
      else $error("out-of-range response carries set data");

   // Path halving never makes a non-root point at itself.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIND_CHK2) |-> (par_rdata_ff != cur_ff))
      else $error("halving step would create a self loop");

   // The clearing pass stays inside the nodes in use.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (CMP_W'(clr_addr_ff) < CMP_W'(node_count_ff)))
      else $error("clearing pass ran past the node count");

endmodule

// ----- tb/tb_union_find_engine_unit.sv -----
`timescale 1ns / 1ps

module tb_union_find_engine_unit;
   import uf_pkg::*;

   localparam int                TABLE_DEPTH = MAX_NODES_DEFAULT;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int                LONG_HOLD   = 400;
   localparam int                SETTLE      = 8;
   localparam int                DRAIN_LIMIT = 20000;
   localparam int                TAIL_CYCLES = 40;
   localparam int                MAX_PRINTS  = 100;

   // One response transaction as the checker sees it.
   typedef struct packed {
      logic              same_set;
      logic [NODE_W-1:0] root_index;
      logic              out_of_range;
   } uf_answer_type;

   // A request whose answer is either typed in or left to the set model.
   typedef struct packed {
      logic          fixed;
      uf_answer_type answer;
   } pinned_answer_type;

   // One line of the directed plan: a node count write or a request.
   typedef struct packed {
      logic              is_write;
      logic [NCNT_W-1:0] wr_value;
      logic [FUNC_W-1:0] func;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic              fixed;
      uf_answer_type     answer;
   } plan_row_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [NCNT_W-1:0] csr_wr_data;

   uf_req_if req_if ();
   uf_rsp_if rsp_if ();

   // Disjoint-set model kept alongside the block.
   logic [NODE_W-1:0] parent_of [TABLE_DEPTH];
   logic [NCNT_W-1:0] set_size  [TABLE_DEPTH];
   logic [NCNT_W-1:0] live_nodes;

   uf_answer_type     answer_q [$];
   pinned_answer_type pinned_q [$];
   plan_row_type      plan     [$];

   int mismatches    = 0;
   int stim_count    = 1024;
   int win_base      = 0;
   bit steady_run    = 1'b0;
   bit long_hold_due = 1'b0;

   union_find_engine_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #10_000_000;
      $display("tb_union_find_engine_unit: FAIL");
      $finish;
   end

   task automatic flag_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= MAX_PRINTS) begin
         $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
      end
   endtask

   // Every node becomes its own root with a set of one.
   function automatic void make_singletons();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         parent_of[i] = NODE_W'(i);
         set_size[i]  = NCNT_W'(1);
      end
   endfunction

   // A node count write clamps into range and rebuilds the sets.
   function automatic void load_node_count(input logic [NCNT_W-1:0] value);
      if (value == '0) begin
         live_nodes = NCNT_W'(1);
      end else if (value > NCNT_W'(TABLE_DEPTH)) begin
         live_nodes = NCNT_W'(TABLE_DEPTH);
      end else begin
         live_nodes = value;
      end
      make_singletons();
   endfunction

   // Root walk with path halving: each node visited is re-pointed to its grandparent.
   function automatic logic [NODE_W-1:0] walk_to_root(input logic [NODE_W-1:0] node);
      logic [NODE_W-1:0] v;
      v = node;
      while (parent_of[v] != v) begin
         parent_of[v] = parent_of[parent_of[v]];
         v = parent_of[v];
      end
      return v;
   endfunction

   // Applies one request to the model and returns the answer it should give.
   function automatic uf_answer_type predict_answer(input logic [FUNC_W-1:0] func,
                                                    input logic [NODE_W-1:0] node_a,
                                                    input logic [NODE_W-1:0] node_b);
      uf_answer_type     ans;
      logic [NODE_W-1:0] ra;
      logic [NODE_W-1:0] rb;
      logic [NODE_W-1:0] lo;
      logic [NODE_W-1:0] hi;
      ans = '0;
      if (func == FUNC_UNUSED) begin
         // The unused selector leaves everything alone and answers with zeros.
      end else if (NCNT_W'(node_a) >= live_nodes ||
                   (func != FUNC_FIND && NCNT_W'(node_b) >= live_nodes)) begin
         ans.out_of_range = 1'b1;
      end else if (func == FUNC_FIND) begin
         ans.root_index = walk_to_root(node_a);
      end else begin
         ra = walk_to_root(node_a);
         rb = walk_to_root(node_b);
         if (ra == rb) begin
            ans.same_set   = 1'b1;
            ans.root_index = ra;
         end else if (func == FUNC_QUERY) begin
            ans.root_index = ra;
         end else begin
            // Smaller set goes under the larger; a tie puts node_a's root under node_b's.
            lo = ra;
            hi = rb;
            if (set_size[ra] > set_size[rb]) begin
               lo = rb;
               hi = ra;
            end
            parent_of[lo] = hi;
            set_size[hi]  = set_size[hi] + set_size[lo];
            ans.root_index = hi;
         end
      end
      return ans;
   endfunction

   // Follows every transaction at the clock edge: model updates and response checks.
   always @(posedge clock) begin : scoreboard
      uf_answer_type     want;
      uf_answer_type     got;
      pinned_answer_type pin;
      if (reset) begin
         live_nodes = NCNT_W'(NODE_COUNT_RESET);
         make_singletons();
      end else begin
         if (csr_wr_en) begin
            load_node_count(csr_wr_data);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.same_set     = rsp_if.same_set;
            got.root_index   = rsp_if.root_index;
            got.out_of_range = rsp_if.out_of_range;
            if (answer_q.size() == 0) begin
               flag_mismatch("response with nothing outstanding", 1, 0);
            end else begin
               want = answer_q.pop_front();
               if (got.same_set !== want.same_set)
                  flag_mismatch("same_set", got.same_set, want.same_set);
               if (got.root_index !== want.root_index)
                  flag_mismatch("root_index", got.root_index, want.root_index);
               if (got.out_of_range !== want.out_of_range)
                  flag_mismatch("out_of_range", got.out_of_range, want.out_of_range);
            end
         end
         if (req_if.valid && req_if.ready) begin
            want = predict_answer(req_if.func, req_if.node_a, req_if.node_b);
            pin  = '0;
            if (pinned_q.size() != 0) pin = pinned_q.pop_front();
            answer_q = {answer_q, (pin.fixed ? pin.answer : want)};
         end
      end
   end

   // Response side: random hold-offs, with one long one on request.
   initial begin : rsp_drain
      int hold;
      rsp_if.ready = 1'b0;
      wait (!reset);
      forever begin
         hold = steady_run ? 0 : $urandom_range(0, 5);
         if (long_hold_due) begin
            hold          = LONG_HOLD;
            long_hold_due = 1'b0;
         end
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // Offers one request transaction and returns at the edge that accepts it.
   task automatic send_req(input logic [FUNC_W-1:0] func, input logic [NODE_W-1:0] node_a,
                           input logic [NODE_W-1:0] node_b, input logic fixed,
                           input uf_answer_type answer);
      int                gap;
      pinned_answer_type pin;
      gap = steady_run ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pin.fixed  = fixed;
      pin.answer = answer;
      pinned_q   = {pinned_q, pin};
      req_if.valid  <= 1'b1;
      req_if.func   <= func;
      req_if.node_a <= node_a;
      req_if.node_b <= node_b;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Waits until the block is idle, then writes the node count.
   task automatic program_node_count(input logic [NCNT_W-1:0] value);
      req_if.valid <= 1'b0;
      while (pinned_q.size() != 0 || answer_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      stim_count = (value == '0) ? 1 : ((value > NCNT_W'(TABLE_DEPTH)) ? TABLE_DEPTH : value);
   endtask

   // Mostly indexes from a narrow window so that sets grow deep, plus extremes and noise.
   function automatic logic [NODE_W-1:0] pick_node();
      int k;
      int v;
      k = $urandom_range(0, 99);
      if (k < 8) begin
         v = $urandom_range(0, 1023);
      end else if (k < 12) begin
         case ($urandom_range(0, 3))
            0:       v = 0;
            1:       v = stim_count - 1;
            2:       v = stim_count;
            default: v = 1023;
         endcase
      end else if (stim_count > 64) begin
         v = (win_base + $urandom_range(0, 47)) % stim_count;
      end else begin
         v = $urandom_range(0, stim_count - 1);
      end
      return v[NODE_W-1:0];
   endfunction

   task automatic run_random_phase(input int n_items);
      int                sent;
      int                r;
      logic [FUNC_W-1:0] func;
      sent = 0;
      while (sent < n_items) begin
         if (sent % 40 == 0) win_base = $urandom_range(0, 1023);
         r = $urandom_range(0, 99);
         if (r < 45)      func = FUNC_MERGE;
         else if (r < 70) func = FUNC_QUERY;
         else if (r < 95) func = FUNC_FIND;
         else             func = FUNC_UNUSED;
         send_req(func, pick_node(), pick_node(), 1'b0, '0);
         sent++;
      end
   endtask

   function automatic plan_row_type row_req(input logic [FUNC_W-1:0] func,
                                            input int node_a, input int node_b);
      plan_row_type row;
      row        = '0;
      row.func   = func;
      row.node_a = NODE_W'(node_a);
      row.node_b = NODE_W'(node_b);
      return row;
   endfunction

   function automatic plan_row_type row_pin(input logic [FUNC_W-1:0] func, input int node_a,
                                            input int node_b, input logic same, input int root,
                                            input logic oor);
      plan_row_type row;
      row              = row_req(func, node_a, node_b);
      row.fixed        = 1'b1;
      row.answer       = '{same_set: same, root_index: NODE_W'(root), out_of_range: oor};
      return row;
   endfunction

   function automatic plan_row_type row_write(input int value);
      plan_row_type row;
      row          = '0;
      row.is_write = 1'b1;
      row.wr_value = NCNT_W'(value);
      return row;
   endfunction

   // Appends one line to the directed plan.
   function automatic void add_row(input plan_row_type row);
      plan = {plan, row};
   endfunction

   // Main stimulus.
   initial begin : stimulus
      int           phase_counts [8];
      int           phase_items  [8];
      int           waited;
      plan_row_type row;

      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_if.valid  = 1'b0;
      req_if.func   = '0;
      req_if.node_a = '0;
      req_if.node_b = '0;

      // Directed plan: singletons after reset, tie and chain merges, then index checks.
      add_row(row_pin(FUNC_FIND, 0, 0, 1'b0, 0, 1'b0));
      add_row(row_pin(FUNC_FIND, 1023, 0, 1'b0, 1023, 1'b0));
      add_row(row_pin(FUNC_QUERY, 0, 1023, 1'b0, 0, 1'b0));
      add_row(row_pin(FUNC_MERGE, 0, 1023, 1'b0, 1023, 1'b0));
      add_row(row_pin(FUNC_MERGE, 1023, 0, 1'b1, 1023, 1'b0));
      add_row(row_pin(FUNC_QUERY, 0, 1023, 1'b1, 1023, 1'b0));
      add_row(row_pin(FUNC_FIND, 0, 512, 1'b0, 1023, 1'b0));
      add_row(row_pin(FUNC_UNUSED, 1023, 1023, 1'b0, 0, 1'b0));
      add_row(row_pin(FUNC_MERGE, 5, 5, 1'b1, 5, 1'b0));
      add_row(row_pin(FUNC_MERGE, 1, 2, 1'b0, 2, 1'b0));
      add_row(row_req(FUNC_MERGE, 3, 1));
      add_row(row_req(FUNC_MERGE, 2, 4));
      add_row(row_req(FUNC_MERGE, 6, 7));
      add_row(row_req(FUNC_MERGE, 8, 6));
      add_row(row_req(FUNC_MERGE, 4, 8));
      add_row(row_req(FUNC_FIND, 3, 0));
      add_row(row_req(FUNC_QUERY, 3, 7));
      add_row(row_write(16));
      add_row(row_pin(FUNC_MERGE, 16, 0, 1'b0, 0, 1'b1));
      add_row(row_pin(FUNC_QUERY, 0, 16, 1'b0, 0, 1'b1));
      add_row(row_pin(FUNC_FIND, 15, 1023, 1'b0, 15, 1'b0));
      add_row(row_pin(FUNC_FIND, 16, 0, 1'b0, 0, 1'b1));
      add_row(row_write(0));
      add_row(row_pin(FUNC_MERGE, 0, 0, 1'b1, 0, 1'b0));
      add_row(row_pin(FUNC_FIND, 1, 0, 1'b0, 0, 1'b1));
      add_row(row_pin(FUNC_QUERY, 1, 0, 1'b0, 0, 1'b1));
      add_row(row_write(2047));
      add_row(row_pin(FUNC_FIND, 1023, 1023, 1'b0, 1023, 1'b0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         row = plan[i];
         if (row.is_write) program_node_count(row.wr_value);
         else send_req(row.func, row.node_a, row.node_b, row.fixed, row.answer);
      end

      // Random phases over a spread of node counts, the extremes among them.
      phase_counts = '{1024, 2, 64, 1, 1024, 300, 1024, 7};
      phase_items  = '{150, 120, 150, 30, 170, 150, 160, 120};
      foreach (phase_counts[p]) begin
         program_node_count(NCNT_W'(phase_counts[p]));
         steady_run = (p == 2 || p == 6);
         // The receiver stalls for a long stretch while requests keep coming.
         if (p == 4) long_hold_due = 1'b1;
         run_random_phase(phase_items[p]);
      end

      // Let the outstanding responses drain, then a short quiet tail.
      req_if.valid <= 1'b0;
      steady_run = 1'b0;
      for (waited = 0; pinned_q.size() != 0 || answer_q.size() != 0; waited++) begin
         if (waited > DRAIN_LIMIT) break;
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (answer_q.size() != 0) flag_mismatch("responses never delivered", answer_q.size(), 0);

      if (mismatches == 0) begin
         $display("tb_union_find_engine_unit: PASS");
      end else begin
         $display("tb_union_find_engine_unit: FAIL");
      end
      $finish;
   end

endmodule

// ----- union_find_engine_unit.f -----
rtl/core/uf_pkg.sv
rtl/core/uf_req_if.sv
rtl/core/uf_rsp_if.sv
rtl/core/union_find_engine_unit.sv
tb/tb_union_find_engine_unit.sv
